FILE: rtl/core/accumulator_machine_execute_assert.svh
// assertion macros for the accumulator machine execute block
`ifndef ACCUMULATOR_MACHINE_EXECUTE_ASSERT_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_ASSERT_SVH

// clocked implication check, off while in reset
`define AME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// plain invariant check, off while in reset
`define AME_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/core/ame_pkg.sv
// shared types and constants of the accumulator machine execute block
package ame_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned IdxW    = $clog2(NumRegs);

  typedef enum logic [4:0] {
    MODE_ADD = 5'd0,
    MODE_SUB = 5'd1,
    MODE_MUL = 5'd2,
    MODE_DIV = 5'd3,
    MODE_LDA = 5'd4,
    MODE_LDK = 5'd5,
    MODE_STA = 5'd6,
    MODE_INP = 5'd7,
    MODE_OUT = 5'd8,
    MODE_HLT = 5'd9,
    MODE_JMP = 5'd10,
    MODE_JEZ = 5'd11,
    MODE_JNE = 5'd12,
    MODE_JLZ = 5'd13,
    MODE_JLE = 5'd14,
    MODE_JGZ = 5'd15,
    MODE_JGE = 5'd16
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIVZ   = 2'd1,
    ERR_INDEX  = 2'd2,
    ERR_DIVOVF = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/core/ame_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module ame_div
  import ame_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, done_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q, quo_q, dvs_q;
  logic [DataW:0]   trial;

  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, sign fixed at the end
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
      quo_q <= req_i.dividend[DataW-1] ? -req_i.dividend : req_i.dividend;
      dvs_q <= req_i.divisor[DataW-1] ? -req_i.divisor : req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;

endmodule

FILE: rtl/core/accumulator_machine_execute.sv
// accumulator register machine execute stage: register file, sequencer, result register
//
// Input channel (in_valid_i/in_ready_o) takes one instruction per request: mode,
// operand and input value. Output channel (res_valid_o/res_ready_i) returns one
// result per instruction: the accumulator after it, out/halt/branch reports and
// an error code.
// Register 0 (the accumulator) sits in a flop; registers 1..15 sit in a
// synchronous memory with a registered read and a valid bit per entry.
// An instruction passes from accept through execute to write back; a div waits
// between the two in a divide state for the one-bit-per-cycle divider.
// One instruction is in flight at a time; the next one is taken as soon as the
// previous one has written back, even while its result still waits at the output.
// If the receiver stalls with a result pending, the next instruction waits in
// write back until the output register is free.
// Reset clears all registers to zero at once through the valid bits and empties
// the output register; no clearing pass is needed.
module accumulator_machine_execute
  import ame_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [4:0]       mode_i,
  input  logic [DataW-1:0] operand_i,
  input  logic [DataW-1:0] input_value_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [DataW-1:0] accumulator_o,
  output logic             out_valid_o,
  output logic [DataW-1:0] out_value_o,
  output logic             halted_o,
  output logic [DataW-1:0] halt_code_o,
  output logic             branch_taken_o,
  output logic [DataW-1:0] branch_target_o,
  output logic [1:0]       error_code_o
);

  state_e state_q, state_d;

  logic [DataW-1:0] mem [NumRegs];
  logic [DataW-1:0] rdata_q;
  logic [NumRegs-1:0] vld_q;

  logic [DataW-1:0] acc_q;
  logic [4:0]       mode_q;
  logic [DataW-1:0] op_q, inval_q;

  // pending result, held from execute to write back
  logic [DataW-1:0] pacc_q, pov_q, phc_q, pbt_q, pwdata_q;
  logic             pout_q, phalt_q, ptaken_q, pwe_q;
  logic [IdxW-1:0]  pidx_q;
  err_e             perr_q;

  logic             res_valid_q;

  logic             accept, exec, wb_fire, div_done;
  logic [IdxW-1:0]  idx;
  logic             idx_ok, cond;
  logic [DataW-1:0] rv, div_quo;
  div_req_t         div_req;

  // execute stage results
  logic [DataW-1:0] x_acc, x_ov, x_hc, x_bt, x_wdata;
  logic             x_out, x_halt, x_we, x_div;
  err_e             x_err;

  assign accept  = in_valid_i && in_ready_o;
  assign exec    = (state_q == S_READ);
  assign wb_fire = (state_q == S_WB) && (!res_valid_q || res_ready_i);

  assign idx    = op_q[IdxW-1:0];
  assign idx_ok = (op_q < DataW'(NumRegs));
  assign rv     = (idx == '0) ? acc_q : (vld_q[idx] ? rdata_q : '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = x_div ? S_DIV : S_WB;
      S_DIV:  if (div_done) state_d = S_WB;
      S_WB:   if (wb_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    x_acc   = acc_q;
    x_ov    = '0;
    x_hc    = '0;
    x_bt    = '0;
    x_wdata = acc_q;
    x_out   = 1'b0;
    x_halt  = 1'b0;
    x_we    = 1'b0;
    x_div   = 1'b0;
    x_err   = ERR_NONE;
    cond    = 1'b0;
    if (mode_q <= 5'(MODE_OUT) && mode_q != 5'(MODE_LDK) && !idx_ok) begin
      x_err = ERR_INDEX;
    end else begin
      case (mode_q)
        MODE_ADD: x_acc = acc_q + rv;
        MODE_SUB: x_acc = acc_q - rv;
        MODE_MUL: x_acc = acc_q * rv;
        MODE_DIV: begin
          if (rv == '0) begin
            x_err = ERR_DIVZ;
          end else if (acc_q == {1'b1, {(DataW-1){1'b0}}} && rv == '1) begin
            x_err = ERR_DIVOVF;
          end else begin
            x_div = 1'b1;
          end
        end
        MODE_LDA: x_acc = rv;
        MODE_LDK: x_acc = op_q;
        MODE_STA: begin
          x_we    = (idx != '0);
          x_wdata = acc_q;
        end
        MODE_INP: begin
          if (idx == '0) x_acc = inval_q;
          x_we    = (idx != '0);
          x_wdata = inval_q;
        end
        MODE_OUT: begin
          x_out = 1'b1;
          x_ov  = rv;
        end
        MODE_HLT: begin
          x_halt = 1'b1;
          x_hc   = op_q;
        end
        MODE_JMP: cond = 1'b1;
        MODE_JEZ: cond = (acc_q == '0);
        MODE_JNE: cond = (acc_q != '0);
        MODE_JLZ: cond = acc_q[DataW-1];
        MODE_JLE: cond = acc_q[DataW-1] || (acc_q == '0);
        MODE_JGZ: cond = !acc_q[DataW-1] && (acc_q != '0);
        MODE_JGE: cond = !acc_q[DataW-1];
        default: ;
      endcase
      if (cond) x_bt = op_q;
    end
  end

  assign div_req.start    = exec && x_div;
  assign div_req.dividend = acc_q;
  assign div_req.divisor  = rv;

  ame_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      vld_q       <= '0;
      acc_q       <= '0;
    end else begin
      state_q <= state_d;
      if (wb_fire) begin
        res_valid_q <= 1'b1;
        acc_q       <= pacc_q;
        if (pwe_q) vld_q[pidx_q] <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      op_q    <= operand_i;
      inval_q <= input_value_i;
    end
    if (exec) begin
      pacc_q   <= x_acc;
      pov_q    <= x_ov;
      phc_q    <= x_hc;
      pbt_q    <= x_bt;
      pout_q   <= x_out;
      phalt_q  <= x_halt;
      ptaken_q <= cond && (x_err == ERR_NONE);
      pwe_q    <= x_we;
      pwdata_q <= x_wdata;
      pidx_q   <= idx;
      perr_q   <= x_err;
    end else if (state_q == S_DIV && div_done) begin
      pacc_q <= div_quo;
    end
    if (wb_fire) begin
      accumulator_o   <= pacc_q;
      out_valid_o     <= pout_q;
      out_value_o     <= pov_q;
      halted_o        <= phalt_q;
      halt_code_o     <= phc_q;
      branch_taken_o  <= ptaken_q;
      branch_target_o <= pbt_q;
      error_code_o    <= perr_q;
    end
  end

  // register file memory, entry 0 unused
  always_ff @(posedge clk_i) begin
    if (wb_fire && pwe_q) mem[pidx_q] <= pwdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= mem[operand_i[IdxW-1:0]];
  end

  assign res_valid_o = res_valid_q;

`include "accumulator_machine_execute_assert.svh"

  `AME_ASSERT(a_accept_to_read, accept |=> state_q == S_READ, "accept did not start a read")
  `AME_ASSERT(a_div_to_wb, (state_q == S_DIV && div_done) |=> state_q == S_WB,
              "divider finish did not reach write back")
  `AME_ASSERT(a_err_no_flags, (res_valid_o && error_code_o != 2'(ERR_NONE)) |->
              (!out_valid_o && !halted_o && !branch_taken_o), "error result carries flags")
  `AME_ASSERT_NEVER(a_no_wr_acc, wb_fire && pwe_q && pidx_q == '0,
                    "memory write to the accumulator entry")

endmodule
